/* src/hrj_pkg.sv */
// Shared types, constants and the output saturation helper of the homography residual block.
`timescale 1ns / 1ps
package hrj_pkg;

    // Field and register widths.
    localparam int PTW   = 24;   // point coordinate, Q15.8
    localparam int CFW   = 48;   // homography coefficient, Q15.32
    localparam int NCOEF = 8;
    localparam int CIW   = 4;    // register index on the write port
    localparam int RESW  = 24;   // residual output width
    localparam int OUTW  = 48;   // Jacobian term output width

    // Internal arithmetic widths.
    localparam int SW    = 74;   // signed sx, sy, w in units of 2^-40
    localparam int MW    = 72;   // magnitude of sx, sy, w
    localparam int LIMB  = 24;   // multiplier limb width
    localparam int NLIMB = 3;    // limbs per magnitude
    localparam int PW    = MW + PTW;  // magnitude times a coordinate
    localparam int W2W   = 2 * MW;    // magnitude of w squared
    localparam int NRW   = 97;   // signed residual numerator
    localparam int QB    = 48;   // quotient bits produced by each divider

    // Divider operand widths: residuals, plain reciprocals, Jacobian terms.
    localparam int RNW = 98;
    localparam int WNW = 74;
    localparam int WDW = MW + 1;
    localparam int JNW = 146;
    localparam int JDW = W2W + 1;

    // Scale shifts between the formats.
    localparam int FRAC_ALIGN = 8;    // Q.32 coefficient times Q.8 point versus Q.32 offset
    localparam int ONE_SHIFT  = 40;   // 1.0 in units of 2^-40
    localparam int SH_PT      = 48;   // point over w into Q31.16
    localparam int SH_ONE     = 56;   // 1.0 over w into Q31.16

    // Register indexes.
    localparam int COEF_R0C0 = 0;
    localparam int COEF_R0C1 = 1;
    localparam int COEF_R0C2 = 2;
    localparam int COEF_R1C0 = 3;
    localparam int COEF_R1C1 = 4;
    localparam int COEF_R1C2 = 5;
    localparam int COEF_R2C0 = 6;
    localparam int COEF_R2C1 = 7;

    // Divider lanes, in the order of the output fields.
    localparam int NDIV    = 11;
    localparam int DIV_RX  = 0;
    localparam int DIV_RY  = 1;
    localparam int DIV_XW  = 2;
    localparam int DIV_YW  = 3;
    localparam int DIV_IW  = 4;
    localparam int DIV_JX6 = 5;
    localparam int DIV_JX7 = 6;
    localparam int DIV_JX8 = 7;
    localparam int DIV_JY6 = 8;
    localparam int DIV_JY7 = 9;
    localparam int DIV_JY8 = 10;

    typedef logic [NCOEF-1:0][CFW-1:0] coef_arr_t;

    localparam logic [CFW-1:0] COEF_ONE = CFW'(64'h1_0000_0000);
    localparam coef_arr_t COEF_RESET = {CFW'(0), CFW'(0), CFW'(0), COEF_ONE,
                                        CFW'(0), CFW'(0), CFW'(0), COEF_ONE};

    // Products of the coefficient rows with the source point: coefficient per lane.
    localparam int PROD_N = 6;
    localparam int PROD_COEF [PROD_N] = '{COEF_R0C0, COEF_R0C1, COEF_R1C0,
                                          COEF_R1C1, COEF_R2C0, COEF_R2C1};

    // Projected point as magnitudes and signs.
    typedef struct packed {
        logic [MW-1:0]  sxm;
        logic [MW-1:0]  sym;
        logic [MW-1:0]  wm;
        logic           sxs;
        logic           sys;
        logic           ws;
        logic           wz;
        logic [PTW-1:0] xm;
        logic [PTW-1:0] ym;
        logic [PTW-1:0] dxm;
        logic [PTW-1:0] dym;
        logic           xs;
        logic           ys;
        logic           dxs;
        logic           dys;
    } proj_t;

    // Divider operands: numerators are 2|n| + |d|, divisors 2|d|.
    typedef struct packed {
        logic [RNW-1:0]  rnx;
        logic [RNW-1:0]  rny;
        logic [WDW-1:0]  wd;
        logic [WNW-1:0]  xn;
        logic [WNW-1:0]  yn;
        logic [WNW-1:0]  on;
        logic [JDW-1:0]  jd;
        logic [JNW-1:0]  jx6;
        logic [JNW-1:0]  jx7;
        logic [JNW-1:0]  jx8;
        logic [JNW-1:0]  jy6;
        logic [JNW-1:0]  jy7;
        logic [JNW-1:0]  jy8;
        logic [NDIV-1:0] neg;
        logic            degen;
    } oper_t;

    // Clamp a quotient magnitude to a signed field of width w and apply the sign.
    function automatic logic [OUTW-1:0] sat_enc(input logic [QB-1:0] q, input logic ovf,
                                                input logic neg, input int w);
        logic [QB:0] lim;
        logic [QB:0] v;
        lim = (QB+1)'(1) << (w - 1);
        if (!neg)
        begin
            lim = lim - 1'b1;
        end
        v = (ovf || ({1'b0, q} > lim)) ? lim : {1'b0, q};
        if (neg)
        begin
            v = -v;
        end
        return v[OUTW-1:0];
    endfunction

endpackage

/* src/hrj_front.sv */
// Projection front end: coefficient products, row sums and magnitudes of sx, sy and w.
`timescale 1ns / 1ps
module hrj_front import hrj_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [PTW-1:0] src_x,
    input  logic signed [PTW-1:0] src_y,
    input  logic signed [PTW-1:0] dst_x,
    input  logic signed [PTW-1:0] dst_y,
    input  coef_arr_t             coef,
    output logic                  out_valid,
    output proj_t                 proj
);

    localparam logic signed [SW-1:0] W_ONE = SW'(1) <<< ONE_SHIFT;

    logic v1_reg, v2_reg, v3_reg;

    logic signed [PTW-1:0]   pt1_reg [4];
    logic signed [PTW-1:0]   pt2_reg [4];
    logic signed [2*PTW-1:0] ph_reg  [PROD_N];
    logic signed [2*PTW:0]   pl_reg  [PROD_N];
    logic signed [2*PTW-1:0] ph_next [PROD_N];
    logic signed [2*PTW:0]   pl_next [PROD_N];
    logic signed [SW-1:0]    sx_reg, sy_reg, w_reg;
    logic signed [SW-1:0]    sx_next, sy_next, w_next;
    proj_t                   proj_reg, proj_next;

    // Stage 1: split each coefficient into a signed high and unsigned low half and multiply.
    always_comb
    begin
        logic signed [CFW-1:0] c;
        logic signed [PTW-1:0] pin;
        for (int k = 0; k < PROD_N; k++)
        begin
            c          = $signed(coef[PROD_COEF[k]]);
            pin        = k[0] ? src_y : src_x;
            ph_next[k] = $signed(c[CFW-1:PTW]) * pin;
            pl_next[k] = $signed({1'b0, c[PTW-1:0]}) * pin;
        end
    end

    // Stage 2: assemble the three rows of the projection.
    always_comb
    begin
        logic signed [SW-1:0] part [PROD_N];
        for (int k = 0; k < PROD_N; k++)
        begin
            part[k] = (SW'(ph_reg[k]) <<< PTW) + SW'(pl_reg[k]);
        end
        sx_next = part[0] + part[1] + (SW'($signed(coef[COEF_R0C2])) <<< FRAC_ALIGN);
        sy_next = part[2] + part[3] + (SW'($signed(coef[COEF_R1C2])) <<< FRAC_ALIGN);
        w_next  = part[4] + part[5] + W_ONE;
    end

    // Stage 3: magnitudes and signs for the unsigned products downstream.
    always_comb
    begin
        proj_next.sxm = sx_reg[SW-1] ? MW'(-sx_reg) : MW'(sx_reg);
        proj_next.sym = sy_reg[SW-1] ? MW'(-sy_reg) : MW'(sy_reg);
        proj_next.wm  = w_reg[SW-1]  ? MW'(-w_reg)  : MW'(w_reg);
        proj_next.sxs = sx_reg[SW-1];
        proj_next.sys = sy_reg[SW-1];
        proj_next.ws  = w_reg[SW-1];
        proj_next.wz  = (w_reg == '0);
        proj_next.xm  = pt2_reg[0][PTW-1] ? PTW'(-pt2_reg[0]) : PTW'(pt2_reg[0]);
        proj_next.ym  = pt2_reg[1][PTW-1] ? PTW'(-pt2_reg[1]) : PTW'(pt2_reg[1]);
        proj_next.dxm = pt2_reg[2][PTW-1] ? PTW'(-pt2_reg[2]) : PTW'(pt2_reg[2]);
        proj_next.dym = pt2_reg[3][PTW-1] ? PTW'(-pt2_reg[3]) : PTW'(pt2_reg[3]);
        proj_next.xs  = pt2_reg[0][PTW-1];
        proj_next.ys  = pt2_reg[1][PTW-1];
        proj_next.dxs = pt2_reg[2][PTW-1];
        proj_next.dys = pt2_reg[3][PTW-1];
    end

    // Valid bits follow the data through the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg[0] <= src_x;
            pt1_reg[1] <= src_y;
            pt1_reg[2] <= dst_x;
            pt1_reg[3] <= dst_y;
            pt2_reg    <= pt1_reg;
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            w_reg      <= w_next;
            proj_reg   <= proj_next;
        end
    end

    assign out_valid = v3_reg;
    assign proj      = proj_reg;

endmodule

/* src/hrj_prod.sv */
// Second-order products and divider operand forming for residuals and Jacobian terms.
`timescale 1ns / 1ps
module hrj_prod import hrj_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  proj_t proj,
    output logic  out_valid,
    output oper_t oper
);

    logic v4_reg, v5_reg, v6_reg, v7_reg;

    logic [2*LIMB-1:0] ww_reg  [6];
    logic [2*LIMB-1:0] sxx_reg [NLIMB];
    logic [2*LIMB-1:0] sxy_reg [NLIMB];
    logic [2*LIMB-1:0] syx_reg [NLIMB];
    logic [2*LIMB-1:0] syy_reg [NLIMB];
    logic [2*LIMB-1:0] dxw_reg [NLIMB];
    logic [2*LIMB-1:0] dyw_reg [NLIMB];
    logic [2*LIMB-1:0] ww_next  [6];
    logic [2*LIMB-1:0] sxx_next [NLIMB];
    logic [2*LIMB-1:0] sxy_next [NLIMB];
    logic [2*LIMB-1:0] syx_next [NLIMB];
    logic [2*LIMB-1:0] syy_next [NLIMB];
    logic [2*LIMB-1:0] dxw_next [NLIMB];
    logic [2*LIMB-1:0] dyw_next [NLIMB];
    proj_t             p4_reg, p5_reg, p6_reg;

    logic [W2W-1:0] w2_reg, w2_next, w2b_reg;
    logic [PW-1:0]  jx6_reg, jx7_reg, jy6_reg, jy7_reg;
    logic [PW-1:0]  jx6_next, jx7_next, jy6_next, jy7_next;
    logic [PW-1:0]  jx6b_reg, jx7b_reg, jy6b_reg, jy7b_reg;
    logic [PW-1:0]  dxw5_reg, dyw5_reg, dxw5_next, dyw5_next;
    logic signed [NRW-1:0] nx_reg, ny_reg, nx_next, ny_next;
    oper_t          oper_reg, oper_next;

    function automatic logic [PW-1:0] sum3(input logic [2*LIMB-1:0] a0,
                                           input logic [2*LIMB-1:0] a1,
                                           input logic [2*LIMB-1:0] a2);
        return PW'(a0) + (PW'(a1) << LIMB) + (PW'(a2) << (2 * LIMB));
    endfunction

    // Stage 4: limb products of w squared and of sx, sy, w with the point coordinates.
    always_comb
    begin
        logic [LIMB-1:0] wl [NLIMB];
        logic [LIMB-1:0] sxl [NLIMB];
        logic [LIMB-1:0] syl [NLIMB];
        for (int i = 0; i < NLIMB; i++)
        begin
            wl[i]  = proj.wm[i*LIMB +: LIMB];
            sxl[i] = proj.sxm[i*LIMB +: LIMB];
            syl[i] = proj.sym[i*LIMB +: LIMB];
        end
        ww_next[0] = wl[0] * wl[0];
        ww_next[1] = wl[0] * wl[1];
        ww_next[2] = wl[0] * wl[2];
        ww_next[3] = wl[1] * wl[1];
        ww_next[4] = wl[1] * wl[2];
        ww_next[5] = wl[2] * wl[2];
        for (int i = 0; i < NLIMB; i++)
        begin
            sxx_next[i] = sxl[i] * proj.xm;
            sxy_next[i] = sxl[i] * proj.ym;
            syx_next[i] = syl[i] * proj.xm;
            syy_next[i] = syl[i] * proj.ym;
            dxw_next[i] = wl[i] * proj.dxm;
            dyw_next[i] = wl[i] * proj.dym;
        end
    end

    // Stage 5: sum the limb products; cross terms of the square count twice.
    always_comb
    begin
        w2_next = W2W'(ww_reg[0])
                + (W2W'(ww_reg[1]) << (LIMB + 1))
                + (W2W'(ww_reg[2]) << (2 * LIMB + 1))
                + (W2W'(ww_reg[3]) << (2 * LIMB))
                + (W2W'(ww_reg[4]) << (3 * LIMB + 1))
                + (W2W'(ww_reg[5]) << (4 * LIMB));
        jx6_next  = sum3(sxx_reg[0], sxx_reg[1], sxx_reg[2]);
        jx7_next  = sum3(sxy_reg[0], sxy_reg[1], sxy_reg[2]);
        jy6_next  = sum3(syx_reg[0], syx_reg[1], syx_reg[2]);
        jy7_next  = sum3(syy_reg[0], syy_reg[1], syy_reg[2]);
        dxw5_next = sum3(dxw_reg[0], dxw_reg[1], dxw_reg[2]);
        dyw5_next = sum3(dyw_reg[0], dyw_reg[1], dyw_reg[2]);
    end

    // Stage 6: signed residual numerators sx*2^8 - dst*w.
    always_comb
    begin
        logic signed [NRW-1:0] ax, ay, bx, by;
        ax = $signed(NRW'(p5_reg.sxm) << FRAC_ALIGN);
        ay = $signed(NRW'(p5_reg.sym) << FRAC_ALIGN);
        bx = $signed(NRW'(dxw5_reg));
        by = $signed(NRW'(dyw5_reg));
        nx_next = (p5_reg.sxs ? -ax : ax) + ((p5_reg.dxs ^ p5_reg.ws) ? bx : -bx);
        ny_next = (p5_reg.sys ? -ay : ay) + ((p5_reg.dys ^ p5_reg.ws) ? by : -by);
    end

    // Stage 7: rounding numerators 2|n| + |d| and divisors 2|d|, with result signs.
    always_comb
    begin
        logic [RNW-1:0] n2x, n2y, wr;
        logic [JNW-1:0] w2j;
        n2x = RNW'(nx_reg) << 1;
        n2y = RNW'(ny_reg) << 1;
        wr  = RNW'(p6_reg.wm);
        w2j = JNW'(w2b_reg);

        oper_next.rnx = nx_reg[NRW-1] ? (wr - n2x) : (wr + n2x);
        oper_next.rny = ny_reg[NRW-1] ? (wr - n2y) : (wr + n2y);
        oper_next.wd  = {p6_reg.wm, 1'b0};
        oper_next.xn  = (WNW'(p6_reg.xm) << (SH_PT + 1)) + WNW'(p6_reg.wm);
        oper_next.yn  = (WNW'(p6_reg.ym) << (SH_PT + 1)) + WNW'(p6_reg.wm);
        oper_next.on  = (WNW'(1) << (SH_ONE + 1)) + WNW'(p6_reg.wm);
        oper_next.jd  = {w2b_reg, 1'b0};
        oper_next.jx6 = (JNW'(jx6b_reg) << (SH_PT + 1)) + w2j;
        oper_next.jx7 = (JNW'(jx7b_reg) << (SH_PT + 1)) + w2j;
        oper_next.jx8 = (JNW'(p6_reg.sxm) << (SH_ONE + 1)) + w2j;
        oper_next.jy6 = (JNW'(jy6b_reg) << (SH_PT + 1)) + w2j;
        oper_next.jy7 = (JNW'(jy7b_reg) << (SH_PT + 1)) + w2j;
        oper_next.jy8 = (JNW'(p6_reg.sym) << (SH_ONE + 1)) + w2j;

        oper_next.neg          = '0;
        oper_next.neg[DIV_RX]  = nx_reg[NRW-1] ^ p6_reg.ws;
        oper_next.neg[DIV_RY]  = ny_reg[NRW-1] ^ p6_reg.ws;
        oper_next.neg[DIV_XW]  = p6_reg.xs ^ p6_reg.ws;
        oper_next.neg[DIV_YW]  = p6_reg.ys ^ p6_reg.ws;
        oper_next.neg[DIV_IW]  = p6_reg.ws;
        oper_next.neg[DIV_JX6] = !(p6_reg.sxs ^ p6_reg.xs);
        oper_next.neg[DIV_JX7] = !(p6_reg.sxs ^ p6_reg.ys);
        oper_next.neg[DIV_JX8] = !p6_reg.sxs;
        oper_next.neg[DIV_JY6] = !(p6_reg.sys ^ p6_reg.xs);
        oper_next.neg[DIV_JY7] = !(p6_reg.sys ^ p6_reg.ys);
        oper_next.neg[DIV_JY8] = !p6_reg.sys;
        oper_next.degen        = p6_reg.wz;
    end

    // Valid bits follow the data through the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg   <= proj;
            ww_reg   <= ww_next;
            sxx_reg  <= sxx_next;
            sxy_reg  <= sxy_next;
            syx_reg  <= syx_next;
            syy_reg  <= syy_next;
            dxw_reg  <= dxw_next;
            dyw_reg  <= dyw_next;

            p5_reg   <= p4_reg;
            w2_reg   <= w2_next;
            jx6_reg  <= jx6_next;
            jx7_reg  <= jx7_next;
            jy6_reg  <= jy6_next;
            jy7_reg  <= jy7_next;
            dxw5_reg <= dxw5_next;
            dyw5_reg <= dyw5_next;

            p6_reg   <= p5_reg;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            w2b_reg  <= w2_reg;
            jx6b_reg <= jx6_reg;
            jx7b_reg <= jx7_reg;
            jy6b_reg <= jy6_reg;
            jy7b_reg <= jy7_reg;

            oper_reg <= oper_next;
        end
    end

    assign out_valid = v7_reg;
    assign oper      = oper_reg;

endmodule

/* src/hrj_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with an overflow check at entry.
`timescale 1ns / 1ps
module hrj_div import hrj_pkg::*; #(
    parameter int NW = 74,
    parameter int DW = 73
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic          neg_in,
    output logic [QB-1:0] quo,
    output logic          ovf,
    output logic          neg_out
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [NW-1:0] r_reg   [QB];
    logic [DW-1:0] d_reg   [QB];
    logic [QB-1:0] q_reg   [1:QB];
    logic          ovf_reg [QB+1];
    logic          neg_reg [QB+1];

    // Entry: the quotient overflows the produced bits when num >= den * 2^QB.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= den;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QB);
            neg_reg[0] <= neg_in;
        end
    end

    // One trial subtraction per stage, most significant quotient bit first.
    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int BIT = QB - 1 - k;
        logic [CW-1:0] trial;
        logic [QB-1:0] q_in;
        logic          ge;

        always_comb
        begin
            trial = CW'(d_reg[k]) << BIT;
            ge    = CW'(r_reg[k]) >= trial;
        end

        if (k == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign q_in = q_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= q_in | (QB'(ge) << BIT);
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end

        if (k < QB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1] <= ge ? NW'(CW'(r_reg[k]) - trial) : r_reg[k];
                    d_reg[k+1] <= d_reg[k];
                end
            end
        end
    end

    assign quo     = q_reg[QB];
    assign ovf     = ovf_reg[QB];
    assign neg_out = neg_reg[QB];

endmodule

/* src/homography_residual_jacobian.sv */
// Top level of the homography reprojection residual and Jacobian pipeline.
`timescale 1ns / 1ps
// Takes one source/destination point pair per cycle and returns the
// x and y reprojection residuals (Q15.8) and the nine distinct Jacobian terms (Q31.16)
// of the projection through the configured homography, whose last coefficient is 1.0.
// Each result is rounded to nearest with ties away from zero and saturated to its
// field; when w is exactly zero the degenerate flag (m_tuser) is set and all data
// fields are zero. The pipeline takes a new item every cycle: 3 stages project the
// point, 4 stages form the squared terms and divider operands, 49 stages run eleven
// bit-per-stage dividers in parallel, and one output register holds the result. A result
// held by m_tready low stalls every stage; nothing is lost. Coefficients are written
// through cfg_we / cfg_index / cfg_wdata and must only change while the pipeline is empty.
module homography_residual_jacobian import hrj_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    // Configuration write port.
    input  logic            cfg_we,
    input  logic [CIW-1:0]  cfg_index,
    input  logic [CFW-1:0]  cfg_wdata,
    // Input items.
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [95:0]     s_tdata,   // src_x, src_y, dst_x, dst_y
    // Result items.
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [479:0]    m_tdata,   // resid_x, resid_y, src_x_over_w, src_y_over_w,
                                       // inv_w, jx_col6, jx_col7, jx_col8,
                                       // jy_col6, jy_col7, jy_col8
    output logic            m_tuser    // degenerate
);

    logic            en;
    coef_arr_t       coef_reg;
    logic            front_valid, prod_valid;
    proj_t           proj;
    oper_t           oper;
    logic [QB-1:0]   quo    [NDIV];
    logic            q_ovf  [NDIV];
    logic            q_neg  [NDIV];
    logic [OUTW-1:0] enc    [NDIV];
    logic            vld_dly_reg [QB+1];
    logic            deg_dly_reg [QB+1];
    logic            m_tvalid_reg;
    logic [479:0]    m_tdata_reg, m_tdata_next;
    logic            m_tuser_reg;

    // The whole pipeline advances unless a finished result is waiting.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we && (cfg_index < CIW'(NCOEF)))
        begin
            coef_reg[cfg_index[$clog2(NCOEF)-1:0]] <= cfg_wdata;
        end
    end

    hrj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .src_x     ($signed(s_tdata[23:0])),
        .src_y     ($signed(s_tdata[47:24])),
        .dst_x     ($signed(s_tdata[71:48])),
        .dst_y     ($signed(s_tdata[95:72])),
        .coef      (coef_reg),
        .out_valid (front_valid),
        .proj      (proj)
    );

    hrj_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .proj      (proj),
        .out_valid (prod_valid),
        .oper      (oper)
    );

    // Residual dividers.
    hrj_div #(.NW(RNW), .DW(WDW)) u_div_rx (
        .clk(clk), .en(en), .num(oper.rnx), .den(oper.wd), .neg_in(oper.neg[DIV_RX]),
        .quo(quo[DIV_RX]), .ovf(q_ovf[DIV_RX]), .neg_out(q_neg[DIV_RX]));
    hrj_div #(.NW(RNW), .DW(WDW)) u_div_ry (
        .clk(clk), .en(en), .num(oper.rny), .den(oper.wd), .neg_in(oper.neg[DIV_RY]),
        .quo(quo[DIV_RY]), .ovf(q_ovf[DIV_RY]), .neg_out(q_neg[DIV_RY]));

    // Point over w and reciprocal of w.
    hrj_div #(.NW(WNW), .DW(WDW)) u_div_xw (
        .clk(clk), .en(en), .num(oper.xn), .den(oper.wd), .neg_in(oper.neg[DIV_XW]),
        .quo(quo[DIV_XW]), .ovf(q_ovf[DIV_XW]), .neg_out(q_neg[DIV_XW]));
    hrj_div #(.NW(WNW), .DW(WDW)) u_div_yw (
        .clk(clk), .en(en), .num(oper.yn), .den(oper.wd), .neg_in(oper.neg[DIV_YW]),
        .quo(quo[DIV_YW]), .ovf(q_ovf[DIV_YW]), .neg_out(q_neg[DIV_YW]));
    hrj_div #(.NW(WNW), .DW(WDW)) u_div_iw (
        .clk(clk), .en(en), .num(oper.on), .den(oper.wd), .neg_in(oper.neg[DIV_IW]),
        .quo(quo[DIV_IW]), .ovf(q_ovf[DIV_IW]), .neg_out(q_neg[DIV_IW]));

    // Perspective Jacobian terms over w squared.
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jx6 (
        .clk(clk), .en(en), .num(oper.jx6), .den(oper.jd), .neg_in(oper.neg[DIV_JX6]),
        .quo(quo[DIV_JX6]), .ovf(q_ovf[DIV_JX6]), .neg_out(q_neg[DIV_JX6]));
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jx7 (
        .clk(clk), .en(en), .num(oper.jx7), .den(oper.jd), .neg_in(oper.neg[DIV_JX7]),
        .quo(quo[DIV_JX7]), .ovf(q_ovf[DIV_JX7]), .neg_out(q_neg[DIV_JX7]));
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jx8 (
        .clk(clk), .en(en), .num(oper.jx8), .den(oper.jd), .neg_in(oper.neg[DIV_JX8]),
        .quo(quo[DIV_JX8]), .ovf(q_ovf[DIV_JX8]), .neg_out(q_neg[DIV_JX8]));
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jy6 (
        .clk(clk), .en(en), .num(oper.jy6), .den(oper.jd), .neg_in(oper.neg[DIV_JY6]),
        .quo(quo[DIV_JY6]), .ovf(q_ovf[DIV_JY6]), .neg_out(q_neg[DIV_JY6]));
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jy7 (
        .clk(clk), .en(en), .num(oper.jy7), .den(oper.jd), .neg_in(oper.neg[DIV_JY7]),
        .quo(quo[DIV_JY7]), .ovf(q_ovf[DIV_JY7]), .neg_out(q_neg[DIV_JY7]));
    hrj_div #(.NW(JNW), .DW(JDW)) u_div_jy8 (
        .clk(clk), .en(en), .num(oper.jy8), .den(oper.jd), .neg_in(oper.neg[DIV_JY8]),
        .quo(quo[DIV_JY8]), .ovf(q_ovf[DIV_JY8]), .neg_out(q_neg[DIV_JY8]));

    // Valid and degenerate bits ride alongside the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QB; i++)
            begin
                vld_dly_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_dly_reg[0] <= prod_valid;
            for (int i = 1; i <= QB; i++)
            begin
                vld_dly_reg[i] <= vld_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_dly_reg[0] <= oper.degen;
            for (int i = 1; i <= QB; i++)
            begin
                deg_dly_reg[i] <= deg_dly_reg[i-1];
            end
        end
    end

    // Saturate, apply signs and pack the result item; a degenerate item packs as zero.
    always_comb
    begin
        for (int k = 0; k < NDIV; k++)
        begin
            enc[k] = sat_enc(quo[k], q_ovf[k], q_neg[k],
                             (k == DIV_RX || k == DIV_RY) ? RESW : OUTW);
        end
        m_tdata_next = {enc[DIV_JY8], enc[DIV_JY7], enc[DIV_JY6],
                        enc[DIV_JX8], enc[DIV_JX7], enc[DIV_JX6],
                        enc[DIV_IW], enc[DIV_YW], enc[DIV_XW],
                        enc[DIV_RY][RESW-1:0], enc[DIV_RX][RESW-1:0]};
        if (deg_dly_reg[QB])
        begin
            m_tdata_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= vld_dly_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= deg_dly_reg[QB];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* src/hrj_chk.sv */
// Port-level checks on the homography residual pipeline, bound to the top level.
`timescale 1ns / 1ps
module hrj_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [479:0] m_tdata,
    input logic         m_tuser
);

    // Input side is held off exactly while a result waits downstream.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // A degenerate result carries all data fields as zero.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero data");

    // A stalled result stays put.
    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // While stalled nothing new can be accepted on the input side.
    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(s_tvalid && s_tready))
        else $error("item accepted while output stalled");

endmodule

bind homography_residual_jacobian hrj_chk u_hrj_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the homography residual and Jacobian pipeline.
`timescale 1ns / 1ps
module tb_top import hrj_pkg::*;;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 120;
    localparam int NFIELD         = 11;
    localparam int BAD_INDEX      = NCOEF;

    typedef logic signed [299:0] wide_t;

    typedef struct packed {
        logic signed [PTW-1:0] dst_y;
        logic signed [PTW-1:0] dst_x;
        logic signed [PTW-1:0] src_y;
        logic signed [PTW-1:0] src_x;
    } point_pair_t;

    typedef struct packed {
        logic [479:0] data;
        logic         degenerate;
    } jac_result_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CIW-1:0]  cfg_index;
    logic [CFW-1:0]  cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [95:0]     s_tdata;   // src_x, src_y, dst_x, dst_y
    logic            m_tvalid;
    logic            m_tready;
    logic [479:0]    m_tdata;   // resid_x, resid_y, src_x_over_w, src_y_over_w, inv_w,
                                // jx_col6, jx_col7, jx_col8, jy_col6, jy_col7, jy_col8
    logic            m_tuser;   // degenerate

    // Shadow copy of the homography coefficients.
    logic signed [CFW-1:0] coef_shadow [NCOEF];
    jac_result_t           pending_results [$];
    int                    mismatches;
    int                    failures;
    bit                    steady_send;
    bit                    steady_recv;
    bit                    hold_request;
    int                    idle_count;

    homography_residual_jacobian i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Rounds n / d to nearest, ties away from zero, and clamps to a signed field.
    function automatic logic [OUTW-1:0] round_quotient(input wide_t n, input wide_t d,
                                                       input int w);
        wide_t na;
        wide_t da;
        wide_t q;
        wide_t lim;
        bit    neg;
        na  = (n < 0) ? -n : n;
        da  = (d < 0) ? -d : d;
        q   = (2 * na + da) / (2 * da);
        neg = (n < 0) != (d < 0);
        if (q == 0)
        begin
            return '0;
        end
        lim = (wide_t'(1) <<< (w - 1)) - (neg ? 0 : 1);
        if (q > lim)
        begin
            q = lim;
        end
        q = neg ? -q : q;
        return q[OUTW-1:0];
    endfunction

    // Projects the source point and forms residuals and Jacobian terms.
    function automatic jac_result_t project_pair(input point_pair_t p);
        wide_t       c [NCOEF];
        wide_t       px, py, qx, qy, sx, sy, w, w2, one;
        jac_result_t r;
        logic [OUTW-1:0] terms [9];
        for (int i = 0; i < NCOEF; i++)
        begin
            c[i] = coef_shadow[i];
        end
        px  = p.src_x;
        py  = p.src_y;
        qx  = p.dst_x;
        qy  = p.dst_y;
        one = 1;
        sx  = c[COEF_R0C0] * px + c[COEF_R0C1] * py + (c[COEF_R0C2] <<< FRAC_ALIGN);
        sy  = c[COEF_R1C0] * px + c[COEF_R1C1] * py + (c[COEF_R1C2] <<< FRAC_ALIGN);
        w   = c[COEF_R2C0] * px + c[COEF_R2C1] * py + (one <<< ONE_SHIFT);
        r   = '0;
        if (w == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        w2 = w * w;
        r.data[23:0]  = RESW'(round_quotient((sx <<< 8) - qx * w, w, RESW));
        r.data[47:24] = RESW'(round_quotient((sy <<< 8) - qy * w, w, RESW));
        terms[0] = round_quotient(px <<< SH_PT, w, OUTW);
        terms[1] = round_quotient(py <<< SH_PT, w, OUTW);
        terms[2] = round_quotient(one <<< SH_ONE, w, OUTW);
        terms[3] = round_quotient(-(sx * px) <<< SH_PT, w2, OUTW);
        terms[4] = round_quotient(-(sx * py) <<< SH_PT, w2, OUTW);
        terms[5] = round_quotient(-sx <<< SH_ONE, w2, OUTW);
        terms[6] = round_quotient(-(sy * px) <<< SH_PT, w2, OUTW);
        terms[7] = round_quotient(-(sy * py) <<< SH_PT, w2, OUTW);
        terms[8] = round_quotient(-sy <<< SH_ONE, w2, OUTW);
        for (int k = 0; k < 9; k++)
        begin
            r.data[48 + 48 * k +: 48] = terms[k];
        end
        return r;
    endfunction

    // Offers a point pair, queues its expected result when taken, then may idle.
    task automatic send_pair(input point_pair_t p);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_results.insert(pending_results.size(), project_pair(p));
        gap = steady_send ? 0 : rand_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Waits until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes one coefficient register; the pipeline must be empty.
    task automatic write_coef(input int idx, input logic [CFW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CIW-1:0];
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx < NCOEF)
        begin
            coef_shadow[idx] = value;
        end
    endtask

    task automatic load_homography(input logic [NCOEF-1:0][CFW-1:0] h);
        for (int i = 0; i < NCOEF; i++)
        begin
            write_coef(i, h[i]);
        end
    endtask

    // Signed value with a magnitude below 2^bits.
    function automatic logic [CFW-1:0] rand_signed(input int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v & ((64'd1 << bits) - 1);
        if ($urandom_range(0, 1))
        begin
            v = -v;
        end
        return v[CFW-1:0];
    endfunction

    function automatic point_pair_t rand_pair();
        point_pair_t p;
        if ($urandom_range(0, 3) == 0)
        begin
            p = {$urandom, $urandom, $urandom};
        end
        else
        begin
            p.src_x = PTW'(rand_signed(17));
            p.src_y = PTW'(rand_signed(17));
            p.dst_x = PTW'(rand_signed(17));
            p.dst_y = PTW'(rand_signed(17));
        end
        return p;
    endfunction

    function automatic point_pair_t make_pair(input int sx_v, input int sy_v,
                                              input int dx_v, input int dy_v);
        point_pair_t p;
        p.src_x = PTW'(sx_v);
        p.src_y = PTW'(sy_v);
        p.dst_x = PTW'(dx_v);
        p.dst_y = PTW'(dy_v);
        return p;
    endfunction

    // Identity homography: coordinate extremes and rounding near zero.
    task automatic test_identity_extremes();
        send_pair(make_pair(0, 0, 0, 0));
        send_pair(make_pair(8388607, 8388607, 8388607, 8388607));
        send_pair(make_pair(-8388608, -8388608, -8388608, -8388608));
        send_pair(make_pair(8388607, -8388608, -8388608, 8388607));
        send_pair(make_pair(1, -1, 0, 0));
        send_pair(make_pair(256, 512, -256, 768));
        send_pair(make_pair(-1, 1, 8388607, -8388608));
        drain_results();
    endtask

    // Perspective row cancels the constant one, so w becomes exactly zero where src_x is 1.0.
    task automatic test_zero_w();
        logic [NCOEF-1:0][CFW-1:0] h;
        h = '0;
        h[COEF_R0C0] = COEF_ONE;
        h[COEF_R1C1] = COEF_ONE;
        h[COEF_R2C0] = -COEF_ONE;
        load_homography(h);
        send_pair(make_pair(256, 1000, 5, 7));
        send_pair(make_pair(256, -8388608, 8388607, -8388608));
        send_pair(make_pair(-256, 3, 4, 5));
        send_pair(make_pair(255, 0, 0, 0));
        send_pair(make_pair(257, 0, 0, 0));
        drain_results();
    endtask

    // Extreme positive and negative coefficients with extreme and small point pairs.
    task automatic test_coef_extremes();
        logic [NCOEF-1:0][CFW-1:0] h;
        h = '0;
        for (int i = 0; i < NCOEF - 2; i++)
        begin
            h[i] = {1'b0, {(CFW-1){1'b1}}};
        end
        load_homography(h);
        send_pair(make_pair(8388607, 8388607, -8388608, -8388608));
        send_pair(make_pair(-8388608, 1, 0, 0));
        send_pair(make_pair(3, -5, 0, 0));
        drain_results();
        for (int i = 0; i < NCOEF; i++)
        begin
            h[i] = {1'b1, {(CFW-1){1'b0}}};
        end
        load_homography(h);
        send_pair(make_pair(8388607, 8388607, 8388607, 8388607));
        send_pair(make_pair(-8388608, -8388608, 0, 0));
        send_pair(make_pair(1, 0, 0, 0));
        drain_results();
        // A write above the last register is ignored.
        write_coef(BAD_INDEX, '0);
        write_coef(CIW'('1), '0);
        send_pair(make_pair(1, 0, 0, 0));
        drain_results();
    endtask

    // Random homographies with random point pairs.
    task automatic test_random_homography(input int n_items, input int persp_bits);
        logic [NCOEF-1:0][CFW-1:0] h;
        for (int i = 0; i < NCOEF; i++)
        begin
            h[i] = rand_signed(i < COEF_R2C0 ? 36 : persp_bits);
        end
        load_homography(h);
        steady_send = ($urandom_range(0, 3) == 0);
        steady_recv = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_items; i++)
        begin
            send_pair(rand_pair());
        end
        drain_results();
        steady_send = 1'b0;
        steady_recv = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering items back to back.
    task automatic test_output_stall();
        steady_send  = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 120; i++)
        begin
            send_pair(rand_pair());
        end
        steady_send = 1'b0;
        drain_results();
    endtask

    // Receiver: random stalls, steady stretches, and one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!steady_recv && $urandom_range(0, 99) < 20)
            begin
                stall_left = rand_gap();
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: compares each result with the oldest expectation.
    always @(posedge clk)
    begin
        jac_result_t exp_r;
        int          lo;
        int          wd;
        logic [47:0] ev;
        logic [47:0] av;
        bit          bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                begin
                    $display("unexpected result item at %0t", $realtime);
                end
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                bad   = 1'b0;
                for (int k = 0; k < NFIELD; k++)
                begin
                    lo = (k < 2) ? 24 * k : 48 + 48 * (k - 2);
                    wd = (k < 2) ? 24 : 48;
                    ev = 48'((exp_r.data >> lo) & ((480'd1 << wd) - 1));
                    av = 48'((m_tdata >> lo) & ((480'd1 << wd) - 1));
                    if (ev !== av)
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                        begin
                            $display("field %0d: expected %h, got %h", k, ev, av);
                        end
                    end
                end
                if (exp_r.degenerate !== m_tuser)
                begin
                    bad = 1'b1;
                    if (mismatches < 10)
                    begin
                        $display("degenerate: expected %b, got %b", exp_r.degenerate, m_tuser);
                    end
                end
                if (bad)
                begin
                    failures++;
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_count = 0;
        end
        else
        begin
            idle_count++;
        end
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        mismatches   = 0;
        failures     = 0;
        idle_count   = 0;
        steady_send  = 1'b0;
        steady_recv  = 1'b0;
        hold_request = 1'b0;
        for (int i = 0; i < NCOEF; i++)
        begin
            coef_shadow[i] = COEF_RESET[i];
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_identity_extremes();
        test_zero_w();
        test_coef_extremes();
        test_random_homography(70, 20);
        test_random_homography(70, 28);
        test_random_homography(70, 12);
        test_random_homography(70, 34);
        test_output_stall();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
